FILE: hw/rtl/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Types and constants shared by the keyed record table and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int KEY_BYTES_DEF = 8;

  typedef enum logic [2:0] {
    OP_SELECT = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_UPDATE = 3'd3,
    OP_PACK   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] key_text;
    logic [7:0]  key_mode;
    logic [63:0] new_key_text;
    logic [7:0]  new_key_mode;
    logic [31:0] data_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [63:0] rec_key_text;
    logic [7:0]  rec_key_mode;
    logic [31:0] rec_data;
    logic        rec_deleted;
    logic [6:0]  used_count;
  } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/keyed_record_table_linear_search.sv
// ----------------------------------------------------------------------------
// keyed_record_table_linear_search
// Record table with select, insert, delete, update and pack, linear scan of
// one RAM holding key text, key mode, data word and deleted mark per entry.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | req_valid / req_stall  | krt_pkg::req_t (operation and keys)
//  rsp     | out | rsp_valid / rsp_stall  | krt_pkg::rsp_t (status and record)
//
//  one transaction at a time; the RAM read port scans one entry per cycle
//  select, delete, update: scan down from the newest entry, stop early on a hit
//  insert and pack: scan up from entry 0, insert stops at a hole; unused mode: no scan
//  a new request is taken while the previous result waits on rsp_stall
//  reset clears the count and control only; no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table_linear_search #(
  parameter int DEPTH     = krt_pkg::DEPTH_DEF,
  parameter int KEY_BYTES = krt_pkg::KEY_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  krt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output krt_pkg::rsp_t rsp
);

  localparam int AW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int TW       = 8 * KEY_BYTES;
  localparam int MARK_BIT = 0;
  localparam int DATA_LO  = 1;
  localparam int MODE_LO  = 33;
  localparam int TEXT_LO  = 41;
  localparam int RW       = TEXT_LO + TW;

  krt_pkg::state_t state, state_next;

  logic [2:0]    op, op_next;
  logic [TW-1:0] kt, kt_next;
  logic [7:0]    km, km_next;
  logic [TW-1:0] nt, nt_next;
  logic [7:0]    nm, nm_next;
  logic [31:0]   dw, dw_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] left, left_next;
  logic [AW-1:0] addr, addr_next;
  logic [CW-1:0] wr_ptr, wr_ptr_next;
  logic          rd_vld, rd_vld_next;
  logic [AW-1:0] rd_addr, rd_addr_next;
  krt_pkg::rsp_t res, res_next;
  logic          rsp_valid_next;
  krt_pkg::rsp_t rsp_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic          ram_re;
  logic [RW-1:0] ram_rdata;

  logic          accept;
  logic          is_search;
  logic          descending;
  logic [TW-1:0] rd_text;
  logic [7:0]    rd_mode;
  logic          rd_mark;
  logic          hit;
  logic          scan_end;
  logic          issue;

  function automatic logic key_eq(logic [TW-1:0] a, logic [TW-1:0] b);
    logic eq;
    logic stop;
    eq   = 1'b1;
    stop = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (!stop && (a[8*i +: 8] != b[8*i +: 8])) begin
        eq = 1'b0;
      end
      if (a[8*i +: 8] == 8'd0) begin
        stop = 1'b1;
      end
    end
    return eq;
  endfunction

  function automatic krt_pkg::rsp_t entry_rsp(logic [AW-1:0] idx, logic [RW-1:0] rec);
    krt_pkg::rsp_t r;
    r              = '0;
    r.status       = krt_pkg::STATUS_OK;
    r.slot         = 6'(idx);
    r.rec_key_text = 64'(rec[TEXT_LO +: TW]);
    r.rec_key_mode = rec[MODE_LO +: 8];
    r.rec_data     = rec[DATA_LO +: 32];
    r.rec_deleted  = rec[MARK_BIT];
    return r;
  endfunction

  krt_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign accept     = req_valid && !req_stall;
  assign is_search  = (op == krt_pkg::OP_SELECT) || (op == krt_pkg::OP_DELETE) ||
                      (op == krt_pkg::OP_UPDATE);
  assign descending = is_search;
  assign rd_text    = ram_rdata[TEXT_LO +: TW];
  assign rd_mode    = ram_rdata[MODE_LO +: 8];
  assign rd_mark    = ram_rdata[MARK_BIT];
  assign hit        = rd_vld &&
                      ((is_search && (rd_mode == km) && key_eq(rd_text, kt)) ||
                       ((op == krt_pkg::OP_INSERT) && (rd_text[7:0] == 8'd0)));
  assign scan_end   = (left == '0) && !rd_vld;
  assign issue      = (state == krt_pkg::S_SCAN) && (left != '0) && !hit;
  assign ram_re     = issue;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      krt_pkg::S_IDLE: begin
        if (req_valid) begin
          if ((req.mode == krt_pkg::OP_SELECT) || (req.mode == krt_pkg::OP_INSERT) ||
              (req.mode == krt_pkg::OP_DELETE) || (req.mode == krt_pkg::OP_UPDATE) ||
              (req.mode == krt_pkg::OP_PACK)) begin
            state_next = krt_pkg::S_SCAN;
          end else begin
            state_next = krt_pkg::S_DONE;
          end
        end
      end
      krt_pkg::S_SCAN: begin
        if (hit || scan_end) begin
          state_next = krt_pkg::S_DONE;
        end
      end
      krt_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = krt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = krt_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_stall      = (state != krt_pkg::S_IDLE);
    op_next        = op;
    kt_next        = kt;
    km_next        = km;
    nt_next        = nt;
    nm_next        = nm;
    dw_next        = dw;
    count_next     = count;
    left_next      = left;
    addr_next      = addr;
    wr_ptr_next    = wr_ptr;
    rd_vld_next    = rd_vld;
    rd_addr_next   = rd_addr;
    res_next       = res;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    ram_we         = 1'b0;
    ram_waddr      = rd_addr;
    ram_wdata      = ram_rdata;
    case (state)
      krt_pkg::S_IDLE: begin
        if (accept) begin
          op_next      = req.mode;
          kt_next      = req.key_text[TW-1:0];
          km_next      = req.key_mode;
          nt_next      = req.new_key_text[TW-1:0];
          nm_next      = req.new_key_mode;
          dw_next      = req.data_word;
          left_next    = count;
          wr_ptr_next  = '0;
          rd_vld_next  = 1'b0;
          res_next     = '0;
          if ((req.mode == krt_pkg::OP_SELECT) || (req.mode == krt_pkg::OP_DELETE) ||
              (req.mode == krt_pkg::OP_UPDATE)) begin
            addr_next = AW'(count - CW'(1));
          end else begin
            addr_next = '0;
          end
        end
      end
      krt_pkg::S_SCAN: begin
        rd_vld_next = issue;
        if (issue) begin
          rd_addr_next = addr;
          left_next    = left - CW'(1);
          addr_next    = descending ? (addr - AW'(1)) : (addr + AW'(1));
        end
        if ((op == krt_pkg::OP_PACK) && rd_vld && !rd_mark) begin
          ram_we      = 1'b1;
          ram_waddr   = AW'(wr_ptr);
          ram_wdata   = ram_rdata;
          wr_ptr_next = wr_ptr + CW'(1);
        end
        if (hit) begin
          case (op)
            krt_pkg::OP_SELECT: begin
              res_next = entry_rsp(rd_addr, ram_rdata);
            end
            krt_pkg::OP_DELETE: begin
              ram_we              = 1'b1;
              ram_wdata           = ram_rdata;
              ram_wdata[MARK_BIT] = 1'b1;
              res_next            = entry_rsp(rd_addr, ram_wdata);
            end
            krt_pkg::OP_UPDATE: begin
              ram_we    = 1'b1;
              ram_wdata = {nt, nm, dw, 1'b0};
              res_next  = entry_rsp(rd_addr, ram_wdata);
            end
            krt_pkg::OP_INSERT: begin
              ram_we    = 1'b1;
              ram_wdata = {kt, km, dw, 1'b0};
              res_next  = entry_rsp(rd_addr, ram_wdata);
            end
            default: begin
              res_next = '0;
            end
          endcase
        end else if (scan_end) begin
          if (op == krt_pkg::OP_INSERT) begin
            if (count == CW'(DEPTH)) begin
              res_next        = '0;
              res_next.status = krt_pkg::STATUS_FULL;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = AW'(count);
              ram_wdata  = {kt, km, dw, 1'b0};
              res_next   = entry_rsp(AW'(count), ram_wdata);
              count_next = count + CW'(1);
            end
          end else if (op == krt_pkg::OP_PACK) begin
            res_next   = '0;
            count_next = wr_ptr;
          end else begin
            res_next        = '0;
            res_next.status = krt_pkg::STATUS_NOT_FOUND;
          end
        end
      end
      krt_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next       = 1'b1;
          rsp_next             = res;
          rsp_next.used_count  = 7'(count);
        end
      end
      default: begin
        rd_vld_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= krt_pkg::S_IDLE;
      count     <= '0;
      left      <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      left      <= left_next;
      rd_vld    <= rd_vld_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    kt      <= kt_next;
    km      <= km_next;
    nt      <= nt_next;
    nm      <= nm_next;
    dw      <= dw_next;
    addr    <= addr_next;
    wr_ptr  <= wr_ptr_next;
    rd_addr <= rd_addr_next;
    res     <= res_next;
    rsp     <= rsp_next;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/krt_ram.sv
// ----------------------------------------------------------------------------
// krt_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: tb/keyed_record_table_linear_search_tb.sv
// ----------------------------------------------------------------------------
// keyed_record_table_linear_search_tb
// Self-checking bench for the keyed record table. A short directed run covers
// an empty table, holes reused by insert, keys that end early on a zero byte,
// duplicate keys, the deleted mark, pack and the unused modes. Random bursts
// follow: fill-heavy runs that reach a full table, mixed traffic and
// delete/pack runs, with keys from a small pool so lookups hit often. Every
// accepted request goes through a table model kept in the bench, and every
// response is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module keyed_record_table_linear_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = krt_pkg::DEPTH_DEF;
  localparam int KEY_BYTES  = krt_pkg::KEY_BYTES_DEF;
  localparam int N_KEYS     = 12;
  localparam int RAND_ITEMS = 1080;
  localparam int TAIL_WAIT  = 80;

  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  localparam logic [63:0] TXT_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TXT_SHORT  = 64'h1122_3344_5500_6677;
  localparam logic [63:0] TXT_ALIAS  = 64'hDEAD_BEEF_CA00_6677;
  localparam logic [63:0] TXT_LONG   = 64'h0102_0304_0506_0708;
  localparam logic [63:0] TXT_LONG_X = 64'hFF02_0304_0506_0708;
  localparam logic [63:0] TXT_TOPBIT = 64'h8000_0000_0000_0001;

  typedef enum int {
    MIX_FILL,
    MIX_MIXED,
    MIX_PURGE
  } mix_t;

  typedef struct {
    krt_pkg::req_t r;
    bit            drain;
    bit            calm;
  } op_item_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          rsp_stall = 1'b0;
  krt_pkg::req_t req       = '0;
  logic          req_stall;
  logic          rsp_valid;
  krt_pkg::rsp_t rsp;

  // table model
  logic [63:0] tbl_text [DEPTH];
  logic [7:0]  tbl_mode [DEPTH];
  logic [31:0] tbl_data [DEPTH];
  bit          tbl_mark [DEPTH];
  int          tbl_count = 0;

  op_item_t      op_q[$];
  krt_pkg::rsp_t table_results_q[$];

  logic [63:0] key_pool [N_KEYS];
  logic [7:0]  kmode_pool [4];

  int       err_cnt   = 0;
  bit       req_fire  = 1'b0;
  bit       calm_now  = 1'b0;
  int       gap_left  = 0;
  int       hold_left = 0;
  op_item_t cur_item;

  keyed_record_table_linear_search dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  function automatic bit key_match(logic [63:0] ta, logic [7:0] ma,
                                   logic [63:0] tb, logic [7:0] mb);
    if (ma != mb) return 1'b0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (ta[8*b +: 8] != tb[8*b +: 8]) return 1'b0;
      if (ta[8*b +: 8] == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic int find_entry(logic [63:0] t, logic [7:0] m);
    for (int i = tbl_count - 1; i >= 0; i--) begin
      if (key_match(tbl_text[i], tbl_mode[i], t, m)) return i;
    end
    return -1;
  endfunction

  function automatic krt_pkg::rsp_t entry_rsp(int i);
    krt_pkg::rsp_t o;
    o = '0;
    o.status       = krt_pkg::STATUS_OK;
    o.slot         = 6'(i);
    o.rec_key_text = tbl_text[i];
    o.rec_key_mode = tbl_mode[i];
    o.rec_data     = tbl_data[i];
    o.rec_deleted  = tbl_mark[i];
    return o;
  endfunction

  function automatic krt_pkg::rsp_t table_apply(krt_pkg::req_t r);
    krt_pkg::rsp_t o;
    logic [63:0]   tmask;
    logic [63:0]   kt;
    logic [63:0]   nt;
    int            f;
    int            n;
    int            k;
    o = '0;
    tmask = '0;
    for (int b = 0; b < KEY_BYTES; b++) tmask[8*b +: 8] = 8'hFF;
    kt = r.key_text & tmask;
    nt = r.new_key_text & tmask;
    case (r.mode)
      krt_pkg::OP_SELECT, krt_pkg::OP_DELETE, krt_pkg::OP_UPDATE: begin
        f = find_entry(kt, r.key_mode);
        if (f < 0) begin
          o.status = krt_pkg::STATUS_NOT_FOUND;
        end else begin
          if (r.mode == krt_pkg::OP_DELETE) begin
            tbl_mark[f] = 1'b1;
          end else if (r.mode == krt_pkg::OP_UPDATE) begin
            tbl_text[f] = nt;
            tbl_mode[f] = r.new_key_mode;
            tbl_data[f] = r.data_word;
            tbl_mark[f] = 1'b0;
          end
          o = entry_rsp(f);
        end
      end
      krt_pkg::OP_INSERT: begin
        n = 0;
        while (n < tbl_count && tbl_text[n][7:0] != 8'h00) n++;
        if (n == tbl_count && tbl_count >= DEPTH) begin
          o.status = krt_pkg::STATUS_FULL;
        end else begin
          if (n == tbl_count) tbl_count++;
          tbl_text[n] = kt;
          tbl_mode[n] = r.key_mode;
          tbl_data[n] = r.data_word;
          tbl_mark[n] = 1'b0;
          o = entry_rsp(n);
        end
      end
      krt_pkg::OP_PACK: begin
        k = 0;
        for (n = 0; n < tbl_count; n++) begin
          if (!tbl_mark[n]) begin
            tbl_text[k] = tbl_text[n];
            tbl_mode[k] = tbl_mode[n];
            tbl_data[k] = tbl_data[n];
            tbl_mark[k] = 1'b0;
            k++;
          end
        end
        tbl_count = k;
      end
      default: begin
      end
    endcase
    o.used_count = 7'(tbl_count);
    return o;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // bytes after the first zero byte do not take part in the compare
  function automatic logic [63:0] key_variant(logic [63:0] t);
    logic [63:0] v;
    bit          zero_seen;
    v = t;
    zero_seen = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (zero_seen) v[8*b +: 8] = 8'($urandom);
      else if (t[8*b +: 8] == 8'h00) zero_seen = 1'b1;
    end
    return v;
  endfunction

  function automatic void pick_key(input bit for_insert, output logic [63:0] t,
                                   output logic [7:0] m);
    int r;
    r = $urandom_range(0, 99);
    if (for_insert && r < 7) begin
      t = rand64();
      t[7:0] = 8'h00;
      m = kmode_pool[$urandom_range(0, 3)];
    end else if (r < 87) begin
      t = key_variant(key_pool[$urandom_range(0, N_KEYS - 1)]);
      m = kmode_pool[$urandom_range(0, 3)];
    end else begin
      t = rand64();
      m = 8'($urandom);
    end
  endfunction

  function automatic logic [2:0] pick_mode(mix_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      MIX_FILL: begin
        if (r < 80) return krt_pkg::OP_INSERT;
        if (r < 90) return krt_pkg::OP_SELECT;
        if (r < 95) return krt_pkg::OP_UPDATE;
        return krt_pkg::OP_DELETE;
      end
      MIX_PURGE: begin
        if (r < 45) return krt_pkg::OP_DELETE;
        if (r < 65) return krt_pkg::OP_SELECT;
        if (r < 80) return krt_pkg::OP_PACK;
        if (r < 90) return krt_pkg::OP_UPDATE;
        return krt_pkg::OP_INSERT;
      end
      default: begin
        if (r < 30) return krt_pkg::OP_SELECT;
        if (r < 55) return krt_pkg::OP_INSERT;
        if (r < 70) return krt_pkg::OP_DELETE;
        if (r < 85) return krt_pkg::OP_UPDATE;
        if (r < 96) return krt_pkg::OP_PACK;
        return 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      end
    endcase
  endfunction

  function automatic void push_op(logic [2:0] md, logic [63:0] kt, logic [7:0] km,
                                  logic [63:0] nt, logic [7:0] nm, logic [31:0] dw,
                                  bit drain, bit calm);
    op_item_t it;
    it.r = '{mode: md, key_text: kt, key_mode: km, new_key_text: nt,
             new_key_mode: nm, data_word: dw};
    it.drain = drain;
    it.calm  = calm;
    op_q.push_back(it);
  endfunction

  // request driver and response stall, both on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      if (!req_valid || req_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (op_q.size() == 0 ||
                     (op_q[0].drain && table_results_q.size() != 0)) begin
          req_valid <= 1'b0;
        end else begin
          cur_item = op_q.pop_front();
          req <= cur_item.r;
          req_valid <= 1'b1;
          calm_now = cur_item.calm;
          gap_left = cur_item.calm ? 0 : pick_gap();
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        hold_left = calm_now ? 0 : pick_gap();
      end
    end
  end

  // transaction monitor
  always @(posedge clk) begin
    krt_pkg::rsp_t want;
    req_fire = !rst && req_valid && !req_stall;
    if (req_fire) table_results_q.push_back(table_apply(req));
    if (!rst && rsp_valid && !rsp_stall) begin
      if (table_results_q.size() == 0) begin
        $error("unexpected response: status %0h slot %0h", rsp.status, rsp.slot);
        err_cnt++;
      end else begin
        want = table_results_q.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("slot", want.slot, rsp.slot);
        check_field("rec_key_text", want.rec_key_text, rsp.rec_key_text);
        check_field("rec_key_mode", want.rec_key_mode, rsp.rec_key_mode);
        check_field("rec_data", want.rec_data, rsp.rec_data);
        check_field("rec_deleted", want.rec_deleted, rsp.rec_deleted);
        check_field("used_count", want.used_count, rsp.used_count);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("keyed_record_table_linear_search_tb: done, errors");
    $finish;
  end

  initial begin
    int          zb;
    int          burst;
    int          len;
    int          work_cnt;
    mix_t        kind;
    bit          calm;
    bit          drain;
    logic [2:0]  md;
    logic [63:0] kt;
    logic [63:0] nt;
    logic [7:0]  km;
    logic [7:0]  nm;

    for (int i = 0; i < N_KEYS; i++) begin
      for (int b = 0; b < 8; b++) key_pool[i][8*b +: 8] = 8'($urandom_range(1, 255));
      if (i % 3 == 2) begin
        zb = $urandom_range(1, 7);
        key_pool[i][8*zb +: 8] = 8'h00;
      end
    end
    // differs from the first key in the last byte only
    key_pool[1] = key_pool[0];
    key_pool[1][63:56] = key_pool[0][63:56] ^ 8'h01;
    kmode_pool = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};

    for (int i = 0; i < DEPTH; i++) begin
      tbl_text[i] = '0;
      tbl_mode[i] = '0;
      tbl_data[i] = '0;
      tbl_mark[i] = 1'b0;
    end

    // directed part
    push_op(krt_pkg::OP_SELECT, TXT_ONES, 8'hFF, rand64(), 8'($urandom), $urandom, 0, 1);
    push_op(krt_pkg::OP_PACK, rand64(), 8'($urandom), rand64(), 8'($urandom), $urandom,
            0, 1);
    push_op(krt_pkg::OP_DELETE, TXT_ONES, 8'hFF, rand64(), 8'($urandom), $urandom, 0, 1);
    push_op(krt_pkg::OP_UPDATE, TXT_ONES, 8'hFF, rand64(), 8'($urandom), $urandom, 0, 1);
    push_op(krt_pkg::OP_INSERT, TXT_ONES, 8'hFF, '0, 8'h00, 32'hFFFF_FFFF, 0, 0);
    push_op(krt_pkg::OP_INSERT, '0, 8'h00, TXT_ONES, 8'hFF, 32'h0, 0, 0);
    push_op(krt_pkg::OP_INSERT, TXT_SHORT, 8'h5A, rand64(), 8'($urandom), $urandom, 0, 0);
    push_op(krt_pkg::OP_INSERT, TXT_LONG, 8'h00, rand64(), 8'($urandom), $urandom, 0, 0);
    push_op(krt_pkg::OP_INSERT, TXT_LONG, 8'h00, rand64(), 8'($urandom), $urandom, 0, 0);
    push_op(krt_pkg::OP_SELECT, TXT_ALIAS, 8'h5A, rand64(), 8'($urandom), $urandom, 0, 0);
    push_op(krt_pkg::OP_SELECT, TXT_LONG, 8'h00, rand64(), 8'($urandom), $urandom, 0, 0);
    push_op(krt_pkg::OP_SELECT, TXT_LONG_X, 8'h00, rand64(), 8'($urandom), $urandom, 0, 0);
    push_op(krt_pkg::OP_SELECT, TXT_ONES, 8'hFE, rand64(), 8'($urandom), $urandom, 0, 0);
    push_op(krt_pkg::OP_DELETE, TXT_LONG, 8'h00, rand64(), 8'($urandom), $urandom, 0, 0);
    push_op(krt_pkg::OP_SELECT, TXT_LONG, 8'h00, rand64(), 8'($urandom), $urandom, 0, 0);
    push_op(krt_pkg::OP_UPDATE, TXT_ONES, 8'hFF, TXT_TOPBIT, 8'h80, 32'h8000_0000, 0, 0);
    push_op(krt_pkg::OP_UPDATE, TXT_SHORT, 8'h5A, '0, 8'h00, $urandom, 0, 0);
    push_op(krt_pkg::OP_INSERT, rand64() | 64'h1, 8'($urandom), rand64(), 8'($urandom),
            $urandom, 0, 0);
    push_op(krt_pkg::OP_DELETE, TXT_TOPBIT, 8'h80, rand64(), 8'($urandom), $urandom, 0, 0);
    push_op(krt_pkg::OP_PACK, rand64(), 8'($urandom), rand64(), 8'($urandom), $urandom,
            0, 0);
    push_op(krt_pkg::OP_SELECT, TXT_LONG, 8'h00, rand64(), 8'($urandom), $urandom, 0, 0);
    for (logic [3:0] u = OP_FIRST_UNUSED; u <= OP_LAST_UNUSED; u++) begin
      push_op(u[2:0], rand64(), 8'($urandom), rand64(), 8'($urandom), $urandom, 0, 0);
    end

    // random bursts, the first one fills the table and waits for a drained block
    burst = 0;
    work_cnt = 0;
    while (work_cnt < RAND_ITEMS) begin
      kind = (burst == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      calm = ($urandom_range(0, 3) == 0);
      drain = (burst == 0) || ($urandom_range(0, 2) == 0);
      len = $urandom_range(30, 90);
      for (int j = 0; j < len; j++) begin
        md = pick_mode(kind);
        pick_key(md == krt_pkg::OP_INSERT, kt, km);
        pick_key(1'b1, nt, nm);
        push_op(md, kt, km, nt, nm, $urandom, drain && j == 0, calm);
        if (md <= krt_pkg::OP_PACK) work_cnt++;
      end
      burst++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
    end while (op_q.size() != 0 || req_valid || table_results_q.size() != 0);
    repeat (TAIL_WAIT) @(posedge clk);

    if (err_cnt == 0) begin
      $display("keyed_record_table_linear_search_tb: done, clean");
    end else begin
      $display("keyed_record_table_linear_search_tb: done, errors");
    end
    $finish;
  end

endmodule
